@@ hdl/sdd_pkg.sv @@
// shared types and constants for the shift-subtract divider register block
// no dependencies; used by sdd_ctrl, sdd_datapath and shift_subtract_divider_regs
`default_nettype none

package sdd_pkg;

    localparam int unsigned QUOTIENT_STEPS = 15;
    localparam int unsigned CNT_W          = $clog2(QUOTIENT_STEPS + 1);
    localparam int unsigned WORD_W         = 16;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned CMD_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DVS_HI = 2'd0,
        CMD_DVS_LO = 2'd1,
        CMD_DVD_HI = 2'd2,
        CMD_DVD_LO = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUBLISH
    } t_state;

    typedef struct packed {
        logic load_dvs_hi;
        logic load_dvs_lo;
        logic load_dvd_hi;
        logic load_dvd_lo;
        logic step;
    } t_dp_ctrl;

endpackage

`default_nettype wire

@@ hdl/shift_subtract_divider_regs.sv @@
// dividend writes and divisor high byte pass through ST_PUBLISH into the output register; a
// divisor low byte first runs ST_RUN, one quotient bit per cycle through the datapath
// subtractor, then ST_PUBLISH, which waits for a free output register. one request is in work
// at a time; a finished result waits in the output register while the next request is taken.
// synchronous active-low reset clears the sequencer, datapath and output valid, not r_o_data.
// top level: byte register interface to the shift-subtract divider
// depends on sdd_pkg, sdd_ctrl, sdd_datapath
`default_nettype none

module shift_subtract_divider_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [sdd_pkg::BYTE_W-1:0]   i_s_axis_tdata,  // data[7:0]
    input  wire logic [sdd_pkg::CMD_W-1:0]    i_s_axis_tuser,  // command[1:0]
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic      [sdd_pkg::WORD_W-1:0]   o_m_axis_tdata   // quotient[15:0]
);

    sdd_pkg::t_dp_ctrl          dp_ctrl;
    logic                       publish;
    logic                       slot_free;
    logic [sdd_pkg::WORD_W-1:0] quotient;
    logic                       r_o_valid, n_o_valid;
    logic [sdd_pkg::WORD_W-1:0] r_o_data;

    assign slot_free = !r_o_valid || i_m_axis_tready;

    sdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_cmd       (i_s_axis_tuser),
        .i_slot_free (slot_free),
        .o_ready     (o_s_axis_tready),
        .o_publish   (publish),
        .o_ctrl      (dp_ctrl)
    );

    sdd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (dp_ctrl),
        .i_byte     (i_s_axis_tdata),
        .o_quotient (quotient)
    );

    always_comb begin
        n_o_valid = r_o_valid;
        if (publish) begin
            n_o_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_o_data <= quotient;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

    a_hi_clears_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.load_dvs_hi |=> quotient == '0)
        else $error("divisor high byte did not clear the quotient");

    a_publish_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        publish |-> slot_free)
        else $error("result loaded over an untaken result");

    a_no_accept_while_stepping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.step |-> !o_s_axis_tready)
        else $error("request taken while divide steps run");

endmodule

`default_nettype wire

@@ hdl/sdd_datapath.sv @@
// register file and one-bit-per-cycle restoring divide step
// depends on sdd_pkg; driven by sdd_ctrl through a t_dp_ctrl struct
`default_nettype none

module sdd_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sdd_pkg::t_dp_ctrl             i_ctrl,
    input  wire logic [sdd_pkg::BYTE_W-1:0]    i_byte,
    output logic      [sdd_pkg::WORD_W-1:0]    o_quotient
);

    logic [sdd_pkg::WORD_W-1:0] r_divisor, n_divisor;
    logic [sdd_pkg::WORD_W-1:0] r_dividend, n_dividend;
    logic [sdd_pkg::WORD_W-1:0] r_rem, n_rem;
    logic [sdd_pkg::WORD_W-1:0] r_quo, n_quo;
    logic [sdd_pkg::WORD_W:0]   diff;
    logic                       rem_ge;

    // one quotient digit per cycle while i_ctrl.step is set
    assign diff   = {1'b0, r_rem} - {1'b0, r_divisor};
    assign rem_ge = ~diff[sdd_pkg::WORD_W];

    always_comb begin
        n_divisor  = r_divisor;
        n_dividend = r_dividend;
        n_rem      = r_rem;
        n_quo      = r_quo;
        if (i_ctrl.load_dvs_hi) begin
            n_divisor = {i_byte, r_divisor[sdd_pkg::BYTE_W-1:0]};
            n_rem     = r_dividend;
            n_quo     = '0;
        end
        if (i_ctrl.load_dvs_lo) begin
            n_divisor = {r_divisor[sdd_pkg::WORD_W-1:sdd_pkg::BYTE_W], i_byte};
        end
        if (i_ctrl.load_dvd_hi) begin
            n_dividend = {i_byte, r_dividend[sdd_pkg::BYTE_W-1:0]};
        end
        if (i_ctrl.load_dvd_lo) begin
            n_dividend = {r_dividend[sdd_pkg::WORD_W-1:sdd_pkg::BYTE_W], i_byte};
        end
        if (i_ctrl.step) begin
            n_quo = {r_quo[sdd_pkg::WORD_W-2:0], rem_ge};
            if (rem_ge) begin
                n_rem = {diff[sdd_pkg::WORD_W-2:0], 1'b0};
            end else begin
                n_rem = {r_rem[sdd_pkg::WORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor  <= '0;
            r_dividend <= '0;
            r_rem      <= '0;
            r_quo      <= '0;
        end else begin
            r_divisor  <= n_divisor;
            r_dividend <= n_dividend;
            r_rem      <= n_rem;
            r_quo      <= n_quo;
        end
    end

    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hdl/sdd_ctrl.sv @@
// sequencer: decodes the request, counts divide steps, hands results out
// depends on sdd_pkg; controls sdd_datapath
`default_nettype none

module sdd_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [sdd_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic                       i_slot_free,
    output logic                            o_ready,
    output logic                            o_publish,
    output sdd_pkg::t_dp_ctrl               o_ctrl
);

    sdd_pkg::t_state           r_state, n_state;
    logic [sdd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      accept;

    assign accept = i_valid && (r_state == sdd_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdd_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == sdd_pkg::CMD_DVS_LO) begin
                        n_state = sdd_pkg::ST_RUN;
                    end else begin
                        n_state = sdd_pkg::ST_PUBLISH;
                    end
                end
            end
            sdd_pkg::ST_RUN: begin
                if (r_cnt == sdd_pkg::CNT_W'(1)) begin
                    n_state = sdd_pkg::ST_PUBLISH;
                end
            end
            sdd_pkg::ST_PUBLISH: begin
                if (i_slot_free) begin
                    n_state = sdd_pkg::ST_IDLE;
                end
            end
            default: n_state = sdd_pkg::ST_IDLE;
        endcase
    end

    // step counter
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = sdd_pkg::CNT_W'(sdd_pkg::QUOTIENT_STEPS);
        end else if (r_state == sdd_pkg::ST_RUN) begin
            n_cnt = r_cnt - sdd_pkg::CNT_W'(1);
        end
    end

    // outputs
    always_comb begin
        o_ready   = 1'b0;
        o_publish = 1'b0;
        o_ctrl    = '0;
        unique case (r_state)
            sdd_pkg::ST_IDLE: begin
                o_ready            = 1'b1;
                o_ctrl.load_dvs_hi = accept && (i_cmd == sdd_pkg::CMD_DVS_HI);
                o_ctrl.load_dvs_lo = accept && (i_cmd == sdd_pkg::CMD_DVS_LO);
                o_ctrl.load_dvd_hi = accept && (i_cmd == sdd_pkg::CMD_DVD_HI);
                o_ctrl.load_dvd_lo = accept && (i_cmd == sdd_pkg::CMD_DVD_LO);
            end
            sdd_pkg::ST_RUN: begin
                o_ctrl.step = 1'b1;
            end
            sdd_pkg::ST_PUBLISH: begin
                o_publish = i_slot_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_divide_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == sdd_pkg::CMD_DVS_LO) |=> r_state == sdd_pkg::ST_RUN)
        else $error("divide request did not start the step sequence");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdd_pkg::ST_RUN) && (r_cnt == sdd_pkg::CNT_W'(1))
        |=> r_state == sdd_pkg::ST_PUBLISH)
        else $error("step sequence did not end after the last step");

    a_run_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdd_pkg::ST_RUN) |-> (r_cnt != '0))
        else $error("step counter underflow");

endmodule

`default_nettype wire

@@ verif/tb_shift_subtract_divider_regs.sv @@
// self-checking testbench for shift_subtract_divider_regs: byte writes in, one quotient per write
// predicts every quotient with its own shift-subtract divider; depends on sdd_pkg and the rtl
`timescale 1ns / 1ps

module tb_shift_subtract_divider_regs;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned DRAIN_EVERY  = 350;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam longint      TIMEOUT_NS   = 5_000_000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_valid = 1'b0;
    logic [sdd_pkg::BYTE_W-1:0]    s_data  = '0;
    sdd_pkg::t_cmd                 s_cmd   = sdd_pkg::CMD_DVD_LO;
    logic                          m_ready = 1'b1;
    logic                          o_s_axis_tready;
    logic                          o_m_axis_tvalid;
    logic [sdd_pkg::WORD_W-1:0]    o_m_axis_tdata;

    shift_subtract_divider_regs dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),   // data[7:0]
        .i_s_axis_tuser  (s_cmd),    // command[1:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)  // quotient[15:0]
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted divider state
    logic [sdd_pkg::WORD_W-1:0] pr_divisor   = '0;
    logic [sdd_pkg::WORD_W-1:0] pr_dividend  = '0;
    logic [sdd_pkg::WORD_W-1:0] pr_remainder = '0;
    logic [sdd_pkg::WORD_W-1:0] pr_quotient  = '0;

    logic [sdd_pkg::WORD_W-1:0] expected_quotients[$];
    logic [sdd_pkg::WORD_W-1:0] head_quotient;

    int errors        = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_divides     = 0;
    int n_zero_div    = 0;
    int burst_left    = 0;

    task automatic predict_quotient(input sdd_pkg::t_cmd cmd,
                                    input logic [sdd_pkg::BYTE_W-1:0] data);
        case (cmd)
            sdd_pkg::CMD_DVS_HI: begin
                pr_divisor[15:8] = data;
                pr_remainder     = pr_dividend;
                pr_quotient      = '0;
            end
            sdd_pkg::CMD_DVS_LO: begin
                pr_divisor[7:0] = data;
                n_divides++;
                if (pr_divisor == '0) n_zero_div++;
                for (int unsigned k = 0; k < sdd_pkg::QUOTIENT_STEPS; k++) begin
                    pr_quotient = pr_quotient << 1;
                    if (pr_remainder >= pr_divisor) begin
                        pr_quotient[0] = 1'b1;
                        pr_remainder   = (pr_remainder - pr_divisor) << 1;
                    end else begin
                        pr_remainder = pr_remainder << 1;
                    end
                end
            end
            sdd_pkg::CMD_DVD_HI: pr_dividend[15:8] = data;
            default:             pr_dividend[7:0]  = data;
        endcase
        expected_quotients.push_back(pr_quotient);
    endtask

    // one request, with burst/gap pacing on the sender side
    task automatic send_write(input sdd_pkg::t_cmd cmd,
                              input logic [sdd_pkg::BYTE_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 2);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_cmd   <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_quotient(cmd, data);
        n_sent++;
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        if (burst_left != 0) begin
            s_valid    <= 1'b0;
            burst_left = 0;
        end
        while (expected_quotients.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_and_divide(input logic [sdd_pkg::WORD_W-1:0] dvd,
                                   input logic [sdd_pkg::WORD_W-1:0] dvs);
        send_write(sdd_pkg::CMD_DVD_HI, dvd[15:8]);
        send_write(sdd_pkg::CMD_DVD_LO, dvd[7:0]);
        send_write(sdd_pkg::CMD_DVS_HI, dvs[15:8]);
        send_write(sdd_pkg::CMD_DVS_LO, dvs[7:0]);
    endtask

    function automatic logic [sdd_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 16'h1 << $urandom_range(0, 15);
            3:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_zero_divisor_after_reset();
        send_write(sdd_pkg::CMD_DVS_LO, 8'h00);
    endtask

    task automatic test_directed_divides();
        load_and_divide(16'hffff, 16'h0001);
        load_and_divide(16'h0000, 16'hffff);
        load_and_divide(16'hffff, 16'hffff);
        load_and_divide(16'h1234, 16'h0000);
        load_and_divide(16'h8000, 16'h00ff);
    endtask

    // low byte again without a fresh high byte, then dividend bytes that must not act yet
    task automatic test_continue_without_reload();
        send_write(sdd_pkg::CMD_DVS_LO, 8'h03);
        send_write(sdd_pkg::CMD_DVD_HI, 8'h7f);
        send_write(sdd_pkg::CMD_DVD_LO, 8'h80);
        send_write(sdd_pkg::CMD_DVS_LO, 8'hff);
    endtask

    task automatic test_random_traffic();
        int                         stop_at;
        int                         next_drain;
        int                         pick;
        logic [sdd_pkg::WORD_W-1:0] dvd;
        logic [sdd_pkg::WORD_W-1:0] dvs;
        stop_at    = n_sent + RANDOM_ITEMS;
        next_drain = n_sent + DRAIN_EVERY;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            dvd  = rand_word();
            dvs  = rand_word();
            if ($urandom_range(0, 1) == 1) dvs = dvs >> $urandom_range(1, 15);
            if (pick < 7) begin
                case ($urandom_range(0, 3))
                    0: begin
                        send_write(sdd_pkg::CMD_DVD_LO, dvd[7:0]);
                        send_write(sdd_pkg::CMD_DVD_HI, dvd[15:8]);
                    end
                    1: ;  // keep the previous dividend
                    default: begin
                        send_write(sdd_pkg::CMD_DVD_HI, dvd[15:8]);
                        send_write(sdd_pkg::CMD_DVD_LO, dvd[7:0]);
                    end
                endcase
                send_write(sdd_pkg::CMD_DVS_HI, dvs[15:8]);
                send_write(sdd_pkg::CMD_DVS_LO, dvs[7:0]);
            end else if (pick < 9) begin
                send_write(sdd_pkg::t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_write(sdd_pkg::CMD_DVS_LO, dvs[7:0]);
            end
            if (n_sent >= next_drain) begin
                wait_drained();
                next_drain = n_sent + DRAIN_EVERY;
            end
        end
    endtask

    // receiver stall pattern, switching among open, coin, sparse and bursty styles
    t_rx_mode rx_mode  = RX_OPEN;
    int       rx_cycle = 0;
    int       rx_hold  = 0;
    logic     rx_level = 1'b1;

    always @(posedge i_clk) begin
        if (rx_cycle % 300 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_ready <= (rx_cycle % 5 == 0);
            default: begin
                if (rx_hold == 0) begin
                    rx_hold  = $urandom_range(1, 20);
                    rx_level = ~rx_level;
                end
                rx_hold--;
                m_ready <= rx_level;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (expected_quotients.size() == 0) begin
                $error("quotient: expected none, actual %h", o_m_axis_tdata);
                errors++;
            end else begin
                head_quotient = expected_quotients.pop_front();
                n_checked++;
                if (o_m_axis_tdata !== head_quotient) begin
                    $error("quotient: expected %h, actual %h", head_quotient, o_m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d quotients outstanding", expected_quotients.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_divisor_after_reset();
        test_directed_divides();
        test_continue_without_reload();
        wait_drained();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_quotients.size() != 0) begin
            $error("quotient: %0d expected results never arrived", expected_quotients.size());
            errors++;
        end

        $display("%0d register writes, %0d divides of which %0d by a zero divisor",
                 n_sent, n_divides, n_zero_div);
        $display("%0d quotients compared, %0d mismatches", n_checked, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
